@@ rtl/xoshiro128_random_generator_assert.svh @@
// Assertion macros shared by the random generator RTL.
`ifndef XOSHIRO128_RANDOM_GENERATOR_ASSERT_SVH
`define XOSHIRO128_RANDOM_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XRG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xrg assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define XRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xrg assertion failed in the following cycle");

`endif

@@ rtl/xrg_pkg.sv @@
// Shared types and constants of the xoshiro128 random generator.
`timescale 1ns / 1ps
package xrg_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [3:0][WORD_W-1:0] gen_state_t;

  localparam gen_state_t SEED_RESET = {32'd0, 32'd0, 32'd0, 32'd1};

  typedef enum logic [2:0] {
    KIND_STAR,
    KIND_PLUS,
    KIND_RANGE,
    KIND_REAL,
    KIND_RESEED,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] span;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SCALE,
    ST_MUL,
    ST_DRAW,
    ST_DIV_Q,
    ST_EMIT
  } back_state_e;

endpackage

@@ rtl/xrg_front.sv @@
// Front end: accepts request beats and classifies them for the back end.
`timescale 1ns / 1ps
module xrg_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [2:0]     action_i,
  input  logic [31:0]    range_low_i,
  input  logic [31:0]    range_high_i,
  input  logic           full_i,
  output logic           push_o,
  output xrg_pkg::entry_t entry_o
);
  import xrg_pkg::*;

  localparam logic [2:0] ActStarstar = 3'd0;
  localparam logic [2:0] ActPlus     = 3'd1;
  localparam logic [2:0] ActRanged   = 3'd2;
  localparam logic [2:0] ActReal     = 3'd3;
  localparam logic [2:0] ActReseed   = 3'd4;

  logic [WORD_W-1:0] span;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign span       = range_high_i - range_low_i + WORD_W'(1);

  always_comb begin
    entry_o.low  = range_low_i;
    entry_o.span = span;
    case (action_i)
      ActStarstar: entry_o.kind = KIND_STAR;
      ActPlus:     entry_o.kind = KIND_PLUS;
      // A range that wraps to zero spans every word and takes one raw draw.
      ActRanged:   entry_o.kind = (span == '0) ? KIND_STAR : KIND_RANGE;
      ActReal:     entry_o.kind = KIND_REAL;
      ActReseed:   entry_o.kind = KIND_RESEED;
      default:     entry_o.kind = KIND_NOP;
    endcase
  end

endmodule

@@ rtl/xrg_fifo.sv @@
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
module xrg_fifo #(
  parameter int unsigned Depth = xrg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xrg_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output xrg_pkg::entry_t entry_o,
  output logic            empty_o
);
  import xrg_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/xrg_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module xrg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::div_req_t req_i,
  output xrg_pkg::div_rsp_t rsp_o
);
  import xrg_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_W + 1);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [WORD_W:0]   trial, diff;

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_comb begin
    trial  = {rem_q, quo_q[WORD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_d = diff[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WORD_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

@@ rtl/xrg_back.sv @@
// Back end: generator state, rejection sampling and the result register.
`timescale 1ns / 1ps
module xrg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xrg_pkg::entry_t     entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  xrg_pkg::gen_state_t seed_i,
  output xrg_pkg::div_req_t   div_req_o,
  input  xrg_pkg::div_rsp_t   div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         value_o
);
  import xrg_pkg::*;

  function automatic gen_state_t advance(input gen_state_t s);
    logic [WORD_W-1:0] t, s0, s1, s2, s3;
    t  = {s[1][WORD_W-10:0], 9'd0};
    s2 = s[2] ^ s[0];
    s3 = s[3] ^ s[1];
    s1 = s[1] ^ s2;
    s0 = s[0] ^ s3;
    s2 = s2 ^ t;
    s3 = {s3[WORD_W-12:0], s3[WORD_W-1:WORD_W-11]};
    return {s3, s2, s1, s0};
  endfunction

  back_state_e       st_q, st_d;
  gen_state_t        gen_q, gen_d, gen_next;
  logic [WORD_W-1:0] low_q, low_d, span_q, span_d, scale_q, scale_d;
  logic [WORD_W-1:0] limit_q, limit_d, res_q, res_d, value_q, value_d;
  logic              out_valid_q, out_valid_d, out_free, load_out;
  logic [WORD_W-1:0] star_a, star_r, star, plus;
  logic [WORD_W-1:0] prod;

  assign star_a   = gen_q[1] + {gen_q[1][WORD_W-3:0], 2'd0};
  assign star_r   = {star_a[WORD_W-8:0], star_a[WORD_W-1:WORD_W-7]};
  assign star     = star_r + {star_r[WORD_W-4:0], 3'd0};
  assign plus     = gen_q[0] + gen_q[3];
  assign gen_next = advance(gen_q);
  assign prod     = span_q * scale_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  always_comb begin
    st_d      = st_q;
    gen_d     = gen_q;
    low_d     = low_q;
    span_d    = span_q;
    scale_d   = scale_q;
    limit_d   = limit_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    div_req_o = '0;
    load_out  = 1'b0;
    value_d   = value_q;
    case (st_q)
      ST_IDLE: begin
        if (!empty_i && out_free && !div_rsp_i.busy) begin
          pop_o = 1'b1;
          case (entry_i.kind)
            KIND_STAR: begin
              load_out = 1'b1;
              value_d  = star;
              gen_d    = gen_next;
            end
            KIND_PLUS: begin
              load_out = 1'b1;
              value_d  = plus;
              gen_d    = gen_next;
            end
            KIND_REAL: begin
              load_out = 1'b1;
              value_d  = {8'd0, plus[WORD_W-1:8]};
              gen_d    = gen_next;
            end
            KIND_RESEED: begin
              load_out = 1'b1;
              value_d  = '0;
              gen_d    = seed_i;
            end
            KIND_RANGE: begin
              low_d              = entry_i.low;
              span_d             = entry_i.span;
              div_req_o.start    = 1'b1;
              div_req_o.dividend = '1;
              div_req_o.divisor  = entry_i.span;
              st_d               = ST_DIV_SCALE;
            end
            default: begin
              load_out = 1'b1;
              value_d  = '0;
            end
          endcase
        end
      end
      ST_DIV_SCALE: begin
        if (div_rsp_i.done) begin
          scale_d = div_rsp_i.quotient;
          st_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        limit_d = prod;
        st_d    = ST_DRAW;
      end
      ST_DRAW: begin
        gen_d = gen_next;
        if (star < limit_q) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = star;
          div_req_o.divisor  = scale_q;
          st_d               = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (div_rsp_i.done) begin
          res_d = div_rsp_i.quotient + low_q;
          st_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          value_d  = res_q;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      gen_q       <= SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    span_q  <= span_d;
    scale_q <= scale_d;
    limit_q <= limit_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

endmodule

@@ rtl/xoshiro128_random_generator.sv @@
// Top level of the xoshiro128 random generator.
// Draws, fractions, reseeds and undefined requests are queued, then finished in the back end's
// idle state, which registers the result; one request can be taken each cycle while the output
// is not stalled and no ranged request is in progress. A ranged request redraws until a draw
// passes rejection, using the shared bit-serial divider twice (scale, then quotient).
// Reset is asynchronous and active low; seeds and state return to 1, 0, 0, 0.
`timescale 1ns / 1ps
module xoshiro128_random_generator #(
  parameter int unsigned QueueDepth = xrg_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xrg_pkg::*;

  `include "xoshiro128_random_generator_assert.svh"

  gen_state_t seed_q;
  entry_t     push_entry, pop_entry;
  logic       push, pop, fifo_full, fifo_empty, cfg_write;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = seed_q[paddr[3:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_write) begin
      seed_q[paddr[3:2]] <= pwdata;
    end
  end

  xrg_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .range_low_i (range_low_i),
    .range_high_i(range_high_i),
    .full_i      (fifo_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  xrg_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (fifo_full),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .empty_o(fifo_empty)
  );

  xrg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  xrg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (pop_entry),
    .empty_i    (fifo_empty),
    .pop_o      (pop),
    .seed_i     (seed_q),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o)
  );

  `XRG_ASSERT_SAME(a_pop_not_empty, clk_i, rst_ni, pop, !fifo_empty)
  `XRG_ASSERT_SAME(a_pop_div_idle, clk_i, rst_ni, pop, !div_rsp.busy)
  `XRG_ASSERT_NEXT(a_fill_after_beat, clk_i, rst_ni, push && fifo_empty, !fifo_empty)

endmodule
